/* src/trsq_pkg.sv */
package trsq_pkg;

  // fixed field widths
  localparam int IDX_W  = 8;   // leaf / node position
  localparam int LVL_W  = 4;   // node_level field
  localparam int VAL_W  = 40;  // stored node value, signed q24.16
  localparam int SUM_W  = 48;  // range sum, signed q32.16
  localparam int CNT_W  = 8;   // nodes used
  localparam int F_W    = 5;   // branching register
  localparam int HREG_W = 4;   // tree_height register
  localparam int ST_W   = 2;   // status field

  // default sizes of the node store
  localparam int DEF_MAX_HEIGHT = 8;
  localparam int DEF_MAX_LEAVES = 256;

  // branching clamp
  localparam logic [F_W-1:0] F_MIN = 5'd2;
  localparam logic [F_W-1:0] F_MAX = 5'd16;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_QUERY_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_WRITE_DONE = 2'd1;
  localparam logic [ST_W-1:0] ST_REJECT     = 2'd2;

  // configuration register indexes
  localparam logic CFG_BRANCHING = 1'b0;
  localparam logic CFG_HEIGHT    = 1'b1;

  // result of the shared divider
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
    logic [F_W-1:0]   rem;
  } div_res_t;

endpackage

/* src/trsq_ram.sv */
module trsq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2304
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/trsq_div.sv */
module trsq_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [trsq_pkg::IDX_W-1:0] dividend_i,
  input  logic [trsq_pkg::F_W-1:0]   divisor_i,
  output trsq_pkg::div_res_t       res_o
);
  import trsq_pkg::*;

  localparam int SW = $clog2(IDX_W);

  logic             running_q, running_d;
  logic             done_q, done_d;
  logic [SW-1:0]    step_q, step_d;
  logic [IDX_W-1:0] quot_q, quot_d;
  logic [F_W-1:0]   rem_q, rem_d;
  logic [F_W:0]     shifted;
  logic [F_W:0]     diff;
  logic             fits;

  // one restoring step per cycle, msb first
  always_comb begin
    shifted   = {rem_q, quot_q[IDX_W-1]};
    diff      = shifted - {1'b0, divisor_i};
    fits      = shifted >= {1'b0, divisor_i};
    running_d = running_q;
    done_d    = 1'b0;
    step_d    = step_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    if (start_i) begin
      running_d = 1'b1;
      step_d    = '0;
      quot_d    = dividend_i;
      rem_d     = '0;
    end else if (running_q) begin
      quot_d = {quot_q[IDX_W-2:0], fits};
      rem_d  = fits ? diff[F_W-1:0] : shifted[F_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == SW'(IDX_W - 1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign res_o = '{done: done_q, quot: quot_q, rem: rem_q};

endmodule

/* src/tree_range_sum_query_core.sv */
// range-sum queries over a b-ary tree of stored node values
//
// command channel: start_i is taken at a clock edge where busy_o is low; the
// beat carries opcode_i and the node / range fields. config: cfg_we_i writes
// cfg_wdata_i to branching (cfg_idx_i 0) or tree_height (cfg_idx_i 1) at once;
// write config only when no command is in flight.
// result channel: done_o is high for exactly one cycle with range_sum_o,
// nodes_used_o and status_o; the receiver cannot hold a result off.
// a node write is stored at the accepting edge and its result beat follows in
// the next cycle; busy_o stays low, so writes run at one per cycle.
// a query holds busy_o high while it walks the tree. it first sizes the tree
// and checks the range, then per level climbed makes two divides of the edge
// indexes by the branching factor on the shared divider, plus level, edge and
// climb steps, with one read from the single store read port for each node
// used; a drain step lands the last read. a bad range is rejected by the range
// check before any walk starts.
// reset sets branching to 2 and tree_height to 8 and idles the sequencer;
// the node store itself is not cleared and must be written before it is read.
module tree_range_sum_query_core #(
  parameter int MAX_HEIGHT = trsq_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_LEAVES = trsq_pkg::DEF_MAX_LEAVES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command beat
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [trsq_pkg::LVL_W-1:0]          node_level_i,
  input  logic [trsq_pkg::IDX_W-1:0]          node_position_i,
  input  logic signed [trsq_pkg::VAL_W-1:0]   node_value_i,
  input  logic [trsq_pkg::IDX_W-1:0]          range_low_i,
  input  logic [trsq_pkg::IDX_W-1:0]          range_high_i,
  // config write port
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [trsq_pkg::F_W-1:0]            cfg_wdata_i,
  // result beat
  output logic                                done_o,
  output logic signed [trsq_pkg::SUM_W-1:0]   range_sum_o,
  output logic [trsq_pkg::CNT_W-1:0]          nodes_used_o,
  output logic [trsq_pkg::ST_W-1:0]           status_o
);
  import trsq_pkg::*;

  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int LW    = $clog2(MAX_LEAVES + 1);
  localparam int DEPTH = (MAX_HEIGHT + 1) * MAX_LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = LW + F_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LEAVES = 10'b0000000010,  // leaf count = min(f^h, max leaves)
    S_CHECK  = 10'b0000000100,  // range check
    S_LEVEL  = 10'b0000001000,  // root read or start divide of lo
    S_DIVLO  = 10'b0000010000,
    S_DIVHI  = 10'b0000100000,
    S_LEFT   = 10'b0001000000,  // stray nodes on the left edge
    S_RIGHT  = 10'b0010000000,  // stray nodes on the right edge
    S_CLIMB  = 10'b0100000000,
    S_DRAIN  = 10'b1000000000   // last read lands, result beat
  } state_e;

  function automatic logic [AW-1:0] node_addr(input logic [HW-1:0] lvl,
                                              input logic [IDX_W-1:0] pos);
    return AW'(lvl) * AW'(MAX_LEAVES) + AW'(pos);
  endfunction

  state_e state_q, state_d;

  logic [F_W-1:0]    branching_q, branching_d;
  logic [HREG_W-1:0] height_q, height_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;

  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]  ql_q, ql_d, qh_q, qh_d;
  logic [F_W-1:0]    rl_q, rl_d, rh_q, rh_d;
  logic [HW-1:0]     lvl_q, lvl_d;
  logic [HW-1:0]     iter_q, iter_d;
  logic [LW-1:0]     leaves_q, leaves_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  out_sum_q, out_sum_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;

  logic [F_W-1:0]    f_eff;
  logic [HW-1:0]     h_eff;
  logic              accept;
  logic              wr_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]  rd_pos;
  logic              rd_issue;
  logic [SUM_W-1:0]  sum_acc;
  logic [PW-1:0]     prod;
  logic              div_start;
  logic [IDX_W-1:0]  div_arg;
  div_res_t          div_res;

  // clamp config into the used range
  always_comb begin
    if (branching_q < F_MIN) begin
      f_eff = F_MIN;
    end else if (branching_q > F_MAX) begin
      f_eff = F_MAX;
    end else begin
      f_eff = branching_q;
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign accept = start_i && (state_q == S_IDLE);
  assign wr_ok  = (32'(node_level_i) <= 32'(MAX_HEIGHT)) &&
                  (32'(node_position_i) < 32'(MAX_LEAVES));
  assign ram_we    = accept && (opcode_i == OP_WRITE) && wr_ok;
  assign ram_waddr = node_addr(HW'(node_level_i), node_position_i);
  assign ram_raddr = node_addr(lvl_q, rd_pos);

  // a read issued last cycle lands now and goes into the running sum
  assign sum_acc = pend_q
                 ? sum_q + {{(SUM_W - VAL_W){ram_rdata[VAL_W-1]}}, ram_rdata}
                 : sum_q;
  assign prod = PW'(leaves_q) * PW'(f_eff);

  always_comb begin
    state_d   = state_q;
    pend_d    = 1'b0;
    done_d    = 1'b0;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ql_d      = ql_q;
    qh_d      = qh_q;
    rl_d      = rl_q;
    rh_d      = rh_q;
    lvl_d     = lvl_q;
    iter_d    = iter_q;
    leaves_d  = leaves_q;
    sum_d     = sum_acc;
    cnt_d     = cnt_q;
    out_sum_d = out_sum_q;
    out_cnt_d = out_cnt_q;
    out_st_d  = out_st_q;
    rd_pos    = lo_q;
    rd_issue  = 1'b0;
    div_start = 1'b0;
    div_arg   = lo_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_WRITE) begin
            done_d    = 1'b1;
            out_sum_d = '0;
            out_cnt_d = '0;
            out_st_d  = wr_ok ? ST_WRITE_DONE : ST_REJECT;
          end else begin
            lo_d     = range_low_i;
            hi_d     = range_high_i;
            lvl_d    = '0;
            iter_d   = '0;
            leaves_d = LW'(1);
            sum_d    = '0;
            cnt_d    = '0;
            state_d  = S_LEAVES;
          end
        end
      end
      S_LEAVES: begin
        if (iter_q == h_eff) begin
          state_d = S_CHECK;
        end else begin
          leaves_d = (prod > PW'(MAX_LEAVES)) ? LW'(MAX_LEAVES) : LW'(prod);
          iter_d   = iter_q + 1'b1;
        end
      end
      S_CHECK: begin
        if ((lo_q > hi_q) || (32'(hi_q) >= 32'(leaves_q))) begin
          done_d    = 1'b1;
          out_sum_d = '0;
          out_cnt_d = '0;
          out_st_d  = ST_REJECT;
          state_d   = S_IDLE;
        end else begin
          state_d = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (lvl_q == h_eff) begin
          // root level: take the root and finish
          rd_pos   = '0;
          rd_issue = 1'b1;
          state_d  = S_DRAIN;
        end else begin
          div_start = 1'b1;
          div_arg   = lo_q;
          state_d   = S_DIVLO;
        end
      end
      S_DIVLO: begin
        if (div_res.done) begin
          ql_d      = div_res.quot;
          rl_d      = div_res.rem;
          div_start = 1'b1;
          div_arg   = hi_q;
          state_d   = S_DIVHI;
        end
      end
      S_DIVHI: begin
        if (div_res.done) begin
          qh_d    = div_res.quot;
          rh_d    = div_res.rem;
          state_d = S_LEFT;
        end
      end
      S_LEFT: begin
        if ((rl_q != '0) && (lo_q < hi_q)) begin
          rd_pos   = lo_q;
          rd_issue = 1'b1;
          lo_d     = lo_q + 1'b1;
          if (rl_q + 1'b1 == f_eff) begin
            rl_d = '0;
            ql_d = ql_q + 1'b1;
          end else begin
            rl_d = rl_q + 1'b1;
          end
        end else begin
          state_d = S_RIGHT;
        end
      end
      S_RIGHT: begin
        if ((rh_q != f_eff - 1'b1) && (lo_q < hi_q)) begin
          rd_pos   = hi_q;
          rd_issue = 1'b1;
          hi_d     = hi_q - 1'b1;
          if (rh_q == '0) begin
            rh_d = f_eff - 1'b1;
            qh_d = qh_q - 1'b1;
          end else begin
            rh_d = rh_q - 1'b1;
          end
        end else begin
          state_d = S_CLIMB;
        end
      end
      S_CLIMB: begin
        if (lo_q != hi_q) begin
          lo_d    = ql_q;
          hi_d    = qh_q;
          lvl_d   = lvl_q + 1'b1;
          state_d = S_LEVEL;
        end else begin
          // both edges met at one node
          rd_pos   = lo_q;
          rd_issue = 1'b1;
          state_d  = S_DRAIN;
        end
      end
      S_DRAIN: begin
        done_d    = 1'b1;
        out_sum_d = sum_acc;
        out_cnt_d = cnt_q;
        out_st_d  = ST_QUERY_DONE;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rd_issue) begin
      pend_d = 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  // config writes
  always_comb begin
    branching_d = branching_q;
    height_d    = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BRANCHING: branching_d = cfg_wdata_i;
        CFG_HEIGHT:    height_d    = cfg_wdata_i[HREG_W-1:0];
        default:       branching_d = branching_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
      branching_q <= F_W'(2);
      height_q    <= HREG_W'(8);
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
      branching_q <= branching_d;
      height_q    <= height_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    ql_q      <= ql_d;
    qh_q      <= qh_d;
    rl_q      <= rl_d;
    rh_q      <= rh_d;
    lvl_q     <= lvl_d;
    iter_q    <= iter_d;
    leaves_q  <= leaves_d;
    sum_q     <= sum_d;
    cnt_q     <= cnt_d;
    out_sum_q <= out_sum_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  // node store, one write and one registered read per cycle
  trsq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (node_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared divider splits an edge index into parent index and child slot
  trsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_arg),
    .divisor_i  (f_eff),
    .res_o      (div_res)
  );

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign range_sum_o  = out_sum_q;
  assign nodes_used_o = out_cnt_q;
  assign status_o     = out_st_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import trsq_pkg::*;

  localparam int STORE_N   = (DEF_MAX_HEIGHT + 1) * DEF_MAX_LEAVES;
  localparam int N_PHASES  = 10;
  localparam int PHASE_LEN = 180;
  localparam int QUIET_AT  = (N_PHASES * PHASE_LEN * 85) / 100;

  // one result beat as the block reports it
  typedef struct packed {
    logic signed [SUM_W-1:0] acc;
    logic [CNT_W-1:0]        cnt;
    logic [ST_W-1:0]         st;
  } result_t;

  // directed rows are either a command beat or a register write
  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic                    op;
    logic [LVL_W-1:0]        lvl;
    logic [IDX_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
    logic                    typed;  // want holds a hand-written expectation
    result_t                 want;
    logic                    reg_idx;
    logic [F_W-1:0]          reg_data;
  } stim_row_t;

  // clock, reset and block inputs, all known from time zero
  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    start_i         = 1'b0;
  logic                    opcode_i        = OP_WRITE;
  logic [LVL_W-1:0]        node_level_i    = '0;
  logic [IDX_W-1:0]        node_position_i = '0;
  logic signed [VAL_W-1:0] node_value_i    = '0;
  logic [IDX_W-1:0]        range_low_i     = '0;
  logic [IDX_W-1:0]        range_high_i    = '0;
  logic                    cfg_we_i        = 1'b0;
  logic                    cfg_idx_i       = CFG_BRANCHING;
  logic [F_W-1:0]          cfg_wdata_i     = '0;

  logic                    busy_o;
  logic                    done_o;
  logic signed [SUM_W-1:0] range_sum_o;
  logic [CNT_W-1:0]        nodes_used_o;
  logic [ST_W-1:0]         status_o;

  // shadow copy of the block: registers and node store
  logic [F_W-1:0]          branch_reg;
  logic [HREG_W-1:0]       height_reg;
  logic signed [VAL_W-1:0] node_mem [STORE_N];
  bit                      node_set [STORE_N];

  int        cover_nodes[$];       // store entries the last walk touched
  result_t   pending_results[$];   // predicted beats, oldest first
  result_t   oldest;
  stim_row_t plan[$];

  int errors    = 0;
  int n_items   = 0;
  int n_writes  = 0;
  int n_queries = 0;
  int n_rejects = 0;
  int n_shapes  = 1;

  // random phases: raw register data, clamped values included
  int phase_f[N_PHASES] = '{2, 16, 3, 0, 31, 4, 2, 16, 7, 1};
  int phase_h[N_PHASES] = '{8, 2, 5, 9, 1, 4, 1, 8, 3, 0};

  tree_range_sum_query_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .node_level_i    (node_level_i),
    .node_position_i (node_position_i),
    .node_value_i    (node_value_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .range_sum_o     (range_sum_o),
    .nodes_used_o    (nodes_used_o),
    .status_o        (status_o)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // effective branching factor after clamping to 2..16
  function automatic int eff_f();
    if (branch_reg < F_MIN) return F_MIN;
    if (branch_reg > F_MAX) return F_MAX;
    return branch_reg;
  endfunction

  // effective root level after clamping to 1..max height
  function automatic int eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
    return height_reg;
  endfunction

  // nodes on one level, capped at the store width; level 0 gives the leaf count
  function automatic int level_size(int lvl);
    int n;
    n = 1;
    for (int i = lvl; i < eff_h(); i++) begin
      n = n * eff_f();
      if (n > DEF_MAX_LEAVES) n = DEF_MAX_LEAVES;
    end
    return n;
  endfunction

  // appends one store entry to the walk record
  function automatic void add_cover(int idx);
    cover_nodes = {cover_nodes, idx};
  endfunction

  // appends one directed row
  function automatic void add_row(stim_row_t r);
    plan = {plan, r};
  endfunction

  // covers [lo_in, hi_in] with the fewest nodes; the touched entries land in
  // cover_nodes so the sender can make sure each was written beforehand
  function automatic result_t tree_cover(logic [IDX_W-1:0] lo_in, logic [IDX_W-1:0] hi_in);
    result_t                 r;
    logic signed [SUM_W-1:0] acc;
    int                      f;
    int                      h;
    int                      lo;
    int                      hi;
    int                      lvl;
    bit                      walking;
    r = '0;
    acc = '0;
    cover_nodes.delete();
    f = eff_f();
    h = eff_h();
    lo = lo_in;
    hi = hi_in;
    if (lo > hi || hi >= level_size(0)) begin
      r.st = ST_REJECT;
      return r;
    end
    lvl = 0;
    walking = 1'b1;
    while (walking) begin
      if (lvl == h) begin
        // climbed all the way: the root stands for everything left
        add_cover(lvl * DEF_MAX_LEAVES);
        walking = 1'b0;
      end else begin
        // loose nodes on the left edge, then on the right edge
        while (lo % f != 0 && lo < hi) begin
          add_cover(lvl * DEF_MAX_LEAVES + lo);
          lo++;
        end
        while (hi % f != f - 1 && lo < hi) begin
          add_cover(lvl * DEF_MAX_LEAVES + hi);
          hi--;
        end
        if (lo != hi) begin
          lo = lo / f;
          hi = hi / f;
          lvl++;
        end else begin
          // both edges met at one node
          add_cover(lvl * DEF_MAX_LEAVES + lo);
          walking = 1'b0;
        end
      end
    end
    foreach (cover_nodes[i]) acc = acc + node_mem[cover_nodes[i]];
    r.acc = acc;
    r.cnt = CNT_W'(cover_nodes.size());
    r.st  = ST_QUERY_DONE;
    return r;
  endfunction

  // applies one accepted beat to the shadow store and returns its result
  function automatic result_t model_apply(logic op, logic [LVL_W-1:0] lvl,
                                          logic [IDX_W-1:0] pos,
                                          logic signed [VAL_W-1:0] val,
                                          logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
    result_t r;
    int      idx;
    r = '0;
    if (op == OP_QUERY) begin
      r = tree_cover(lo, hi);
    end else if (lvl > DEF_MAX_HEIGHT) begin
      r.st = ST_REJECT;  // level outside the store, nothing kept
    end else begin
      idx = lvl * DEF_MAX_LEAVES + pos;
      node_mem[idx] = val;
      node_set[idx] = 1'b1;
      r.st = ST_WRITE_DONE;
    end
    return r;
  endfunction

  // node value with the extremes mixed in
  function automatic logic signed [VAL_W-1:0] rand_val();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: return {1'b0, {(VAL_W-1){1'b1}}};
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return w[VAL_W-1:0];
    endcase
  endfunction

  function automatic stim_row_t cmd_row(logic op, logic [LVL_W-1:0] lvl,
                                        logic [IDX_W-1:0] pos,
                                        logic signed [VAL_W-1:0] val,
                                        logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CMD;
    r.op   = op;
    r.lvl  = lvl;
    r.pos  = pos;
    r.val  = val;
    r.lo   = lo;
    r.hi   = hi;
    return r;
  endfunction

  function automatic stim_row_t checked(stim_row_t r, logic signed [SUM_W-1:0] acc,
                                        logic [CNT_W-1:0] cnt, logic [ST_W-1:0] st);
    r.typed    = 1'b1;
    r.want.acc = acc;
    r.want.cnt = cnt;
    r.want.st  = st;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [F_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // presents one command beat and holds it until the block takes it; start_i
  // is left high so a following beat goes out back to back
  task automatic issue_cmd(logic op, logic [LVL_W-1:0] lvl, logic [IDX_W-1:0] pos,
                           logic signed [VAL_W-1:0] val, logic [IDX_W-1:0] lo,
                           logic [IDX_W-1:0] hi, logic typed, result_t want);
    result_t r;
    start_i         <= 1'b1;
    opcode_i        <= op;
    node_level_i    <= lvl;
    node_position_i <= pos;
    node_value_i    <= val;
    range_low_i     <= lo;
    range_high_i    <= hi;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // taken at this edge
    r = model_apply(op, lvl, pos, val, lo, hi);
    pending_results = {pending_results, (typed ? want : r)};
    n_items++;
    if (r.st == ST_REJECT) n_rejects++;
    else if (op == OP_QUERY) n_queries++;
    else n_writes++;
  endtask

  // a query may only read written nodes, so any gap is written first
  task automatic send_item(logic op, logic [LVL_W-1:0] lvl, logic [IDX_W-1:0] pos,
                           logic signed [VAL_W-1:0] val, logic [IDX_W-1:0] lo,
                           logic [IDX_W-1:0] hi, logic typed, result_t want);
    int need[$];
    if (op == OP_QUERY) begin
      void'(tree_cover(lo, hi));
      need = cover_nodes;
      foreach (need[i]) begin
        if (!node_set[need[i]]) begin
          issue_cmd(OP_WRITE, LVL_W'(need[i] / DEF_MAX_LEAVES),
                    IDX_W'(need[i] % DEF_MAX_LEAVES), rand_val(),
                    IDX_W'($urandom()), IDX_W'($urandom()), 1'b0, '0);
        end
      end
    end
    issue_cmd(op, lvl, pos, val, lo, hi, typed, want);
  endtask

  task automatic pause_sender(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // drops start and waits for the block to go quiet; anything still owed
  // after the bound is reported as missing
  task automatic settle(int tail);
    int waited;
    start_i <= 1'b0;
    waited = 0;
    while ((pending_results.size() != 0 || busy_o) && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_results.size());
      errors++;
      pending_results.delete();
    end
    repeat (tail) @(posedge clk_i);
  endtask

  // register write, then a wait with the enable low so it drops cleanly
  task automatic write_reg(logic idx, logic [F_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_BRANCHING) branch_reg = data;
    else height_reg = data[HREG_W-1:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker: every done_o beat must match the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d", status_o);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (range_sum_o !== oldest.acc) begin
          $error("range_sum mismatch: expected %0d, got %0d",
                 $signed(oldest.acc), range_sum_o);
          errors++;
        end
        if (nodes_used_o !== oldest.cnt) begin
          $error("nodes_used mismatch: expected %0d, got %0d", oldest.cnt, nodes_used_o);
          errors++;
        end
        if (status_o !== oldest.st) begin
          $error("status mismatch: expected %0d, got %0d", oldest.st, status_o);
          errors++;
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #(64'd200_000_000);
    $display("tree_range_sum_query_core test failed");
    $finish;
  end

  initial begin
    stim_row_t               row;
    logic                    op;
    logic [LVL_W-1:0]        lvl;
    logic [IDX_W-1:0]        pos;
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
    int                      leaves;
    int                      pick;
    int                      sent;
    int                      base;
    bit                      idling;

    // shadow state matches the block coming out of reset
    branch_reg = F_MIN;
    height_reg = HREG_W'(DEF_MAX_HEIGHT);
    foreach (node_set[i]) begin
      node_set[i] = 1'b0;
      node_mem[i] = '0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset shape first: binary tree of height 8, 256 leaves
    // a single leaf with the largest value comes back alone
    add_row(checked(cmd_row(OP_WRITE, 0, 5, {1'b0, {(VAL_W-1){1'b1}}}, 0, 0),
                    0, 0, ST_WRITE_DONE));
    add_row(checked(cmd_row(OP_QUERY, 0, 0, 0, 5, 5),
                    48'sd549755813887, 1, ST_QUERY_DONE));
    // full leaf range collapses onto the root holding the most negative value
    add_row(checked(cmd_row(OP_WRITE, 8, 0, {1'b1, {(VAL_W-1){1'b0}}}, 0, 0),
                    0, 0, ST_WRITE_DONE));
    add_row(checked(cmd_row(OP_QUERY, 0, 0, 0, 0, 255),
                    -48'sd549755813888, 1, ST_QUERY_DONE));
    add_row(checked(cmd_row(OP_WRITE, 0, 0, 0, 0, 0), 0, 0, ST_WRITE_DONE));
    // writes to levels past the store are refused
    add_row(checked(cmd_row(OP_WRITE, 9, 3, 40'sd77, 0, 0), 0, 0, ST_REJECT));
    add_row(checked(cmd_row(OP_WRITE, 15, 255, '1, 255, 255), 0, 0, ST_REJECT));
    // inverted ranges are refused
    add_row(checked(cmd_row(OP_QUERY, 0, 0, 0, 200, 100), 0, 0, ST_REJECT));
    add_row(checked(cmd_row(OP_QUERY, 15, 255, '1, 255, 0), 0, 0, ST_REJECT));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 0, 0));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 255, 255));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 1, 254));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 0, 127));
    add_row(checked(cmd_row(OP_WRITE, 4, 15, '1, 0, 0), 0, 0, ST_WRITE_DONE));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 3, 200));
    add_row(checked(cmd_row(OP_WRITE, 8, 255, 40'sd1, 0, 0), 0, 0, ST_WRITE_DONE));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 254, 255));
    // branching below 2 and height 0 clamp to a two-leaf tree
    add_row(cfg_row(CFG_BRANCHING, 5'd1));
    add_row(cfg_row(CFG_HEIGHT, 5'd0));
    add_row(checked(cmd_row(OP_QUERY, 0, 0, 0, 0, 2), 0, 0, ST_REJECT));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 0, 1));
    // branching above 16 and height above the store clamp to 16 / 8
    add_row(cfg_row(CFG_BRANCHING, 5'd31));
    add_row(cfg_row(CFG_HEIGHT, 5'd31));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 17, 250));
    add_row(cmd_row(OP_QUERY, 0, 0, 0, 0, 255));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle(4);
        write_reg(row.reg_idx, row.reg_data);
        n_shapes++;
      end else begin
        send_item(row.op, row.lvl, row.pos, row.val, row.lo, row.hi, row.typed, row.want);
      end
    end

    // random part: one tree shape per phase, idle bursts off in the tail;
    // gap-filling writes count toward each phase's share of beats
    sent = 0;
    base = n_items;
    idling = 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      settle(4);
      write_reg(CFG_BRANCHING, F_W'(phase_f[p]));
      write_reg(CFG_HEIGHT, {1'($urandom_range(0, 1)), HREG_W'(phase_h[p])});
      n_shapes++;
      leaves = level_size(0);
      while (n_items - base < (p + 1) * PHASE_LEN) begin
        if (sent % 40 == 0) idling = ($urandom_range(0, 2) != 0);
        if (n_items - base >= QUIET_AT) idling = 1'b0;
        if (idling && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 18));

        // fields the opcode ignores still get random content
        lvl = LVL_W'($urandom());
        pos = IDX_W'($urandom());
        lo  = IDX_W'($urandom());
        hi  = IDX_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          op = OP_QUERY;
          case ($urandom_range(0, 9))
            0: begin
              lo = IDX_W'($urandom_range(1, 255));
              hi = IDX_W'($urandom_range(0, lo - 1));
            end
            1: begin
              // past the last leaf when the tree is narrower than the store
              if (leaves < DEF_MAX_LEAVES) begin
                hi = IDX_W'($urandom_range(leaves, 255));
                lo = IDX_W'($urandom_range(0, hi));
              end
            end
            2: begin
              lo = IDX_W'($urandom_range(0, leaves - 1));
              hi = lo;
            end
            3: begin
              lo = 0;
              hi = IDX_W'(leaves - 1);
            end
            default: begin
              lo = IDX_W'($urandom_range(0, leaves - 1));
              hi = IDX_W'($urandom_range(lo, leaves - 1));
            end
          endcase
        end else if (pick < 95) begin
          op = OP_WRITE;
          if ($urandom_range(0, 7) == 0) begin
            lvl = LVL_W'($urandom_range(0, DEF_MAX_HEIGHT));
          end else begin
            lvl = LVL_W'($urandom_range(0, eff_h()));
            pos = IDX_W'($urandom_range(0, level_size(lvl) - 1));
          end
        end else begin
          op = OP_WRITE;
          lvl = LVL_W'($urandom_range(DEF_MAX_HEIGHT + 1, 15));
        end
        send_item(op, lvl, pos, rand_val(), lo, hi, 1'b0, '0);
        sent++;
      end
    end

    // wait for the last results to arrive, then leave an idle tail
    settle(400);

    $display("covered %0d node writes, %0d range queries and %0d rejected commands",
             n_writes, n_queries, n_rejects);
    $display("over %0d tree shapes, including clamped branching and height settings",
             n_shapes);
    if (errors == 0) begin
      $display("tree_range_sum_query_core test passed");
    end else begin
      $display("tree_range_sum_query_core test failed");
    end
    $finish;
  end

endmodule
